>>> design/jdb_pkg.sv
// Shared types, constants and codes for the jack detect and button debounce block.
package jdb_pkg;

  // Hold counter width; counters saturate at all ones.
  localparam int unsigned HoldBits    = 8;
  localparam int unsigned CfgTickBits = 8;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CmpBits     = (HoldBits > CfgTickBits) ? HoldBits : CfgTickBits;

  localparam logic [HoldBits-1:0] HoldMax = '1;

  typedef logic [HoldBits-1:0]    hold_t;
  typedef logic [CfgTickBits-1:0] ticks_t;
  typedef logic [CmpBits-1:0]     cmp_t;

  typedef enum logic [1:0] {
    KeyNone  = 2'd0,
    KeyMedia = 2'd1,
    KeyEnd   = 2'd2
  } key_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgDetectInvert   = 3'd0,
    CfgButtonInvert   = 3'd1,
    CfgDetectDebounce = 3'd2,
    CfgButtonDebounce = 3'd3,
    CfgLongPress      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic   detect_invert;
    logic   button_invert;
    ticks_t detect_debounce;
    ticks_t button_debounce;
    ticks_t long_press;
  } jdb_cfg_t;

  // Detect channel events for this tick.
  typedef struct packed {
    logic plug_in;
    logic removal;
  } jdb_evt_t;

endpackage

>>> design/jdb_detect.sv
// Jack detect channel: polarity, hold counter, plug-in and removal events.
module jdb_detect
  import jdb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  logic     pin_i,
  input  jdb_cfg_t cfg_i,
  output jdb_evt_t evt_o,
  output logic     jack_d_o
);

  logic  level_q, level_d;
  hold_t hold_q, hold_d;
  logic  counting_q, counting_d;
  logic  jack_q, jack_d;
  logic  act;

  assign act = pin_i ^ cfg_i.detect_invert;

  always_comb begin
    level_d    = level_q;
    hold_d     = hold_q;
    counting_d = counting_q;
    jack_d     = jack_q;
    evt_o      = '0;
    if (act != level_q) begin
      level_d    = act;
      hold_d     = '0;
      counting_d = 1'b1;
    end else if (counting_q && (hold_q != HoldMax)) begin
      hold_d = hold_q + hold_t'(1);
      if (!level_q) begin
        counting_d    = 1'b0;
        jack_d        = 1'b0;
        evt_o.removal = 1'b1;
      end else if (cmp_t'(hold_d) == cmp_t'(cfg_i.detect_debounce)) begin
        counting_d    = 1'b0;
        jack_d        = 1'b1;
        evt_o.plug_in = 1'b1;
      end
    end
  end

  assign jack_d_o = jack_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= 1'b0;
      hold_q     <= '0;
      counting_q <= 1'b0;
      jack_q     <= 1'b0;
    end else if (step_i) begin
      level_q    <= level_d;
      hold_q     <= hold_d;
      counting_q <= counting_d;
      jack_q     <= jack_d;
    end
  end

  // plug-in only ever reported on an active level
  a_plug_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(jack_q) |-> level_q)
    else $error("jack reported in while detect level inactive");

endmodule

>>> design/jdb_button.sv
// Button channel: debounce, press steps and key pulses, gated by jack state.
module jdb_button
  import jdb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  logic     pin_i,
  input  jdb_cfg_t cfg_i,
  input  jdb_evt_t evt_i,
  output key_e     key_o,
  output logic     armed_d_o
);

  logic        level_q, level_d;
  hold_t       hold_q, hold_d;
  logic        counting_q, counting_d;
  logic        en_q, en_d;
  logic [1:0]  step_q, step_d;
  logic        act;
  logic        hit;

  assign act = pin_i ^ cfg_i.button_invert;

  always_comb begin
    level_d    = level_q;
    hold_d     = hold_q;
    counting_d = counting_q;
    en_d       = en_q;
    step_d     = step_q;
    key_o      = KeyNone;
    hit        = 1'b0;
    if (en_q) begin
      if (act != level_q) begin
        level_d    = act;
        hold_d     = '0;
        counting_d = 1'b1;
      end else if (counting_q && (hold_q != HoldMax)) begin
        hold_d = hold_q + hold_t'(1);
        hit = (cmp_t'(hold_d) >= cmp_t'(cfg_i.button_debounce)) &&
              ((cmp_t'(hold_d) == cmp_t'(cfg_i.button_debounce)) ||
               (cmp_t'(hold_d) == cmp_t'(cfg_i.long_press)));
        if (hit) begin
          if (level_q) begin
            step_d = step_q + 2'd1;  // 3 wraps to 0
            if (step_d == 2'd2) begin
              key_o = KeyEnd;
            end
          end else begin
            if (step_q == 2'd1) begin
              key_o = KeyMedia;
            end
            step_d     = 2'd0;
            counting_d = 1'b0;
          end
        end
      end
    end
    // detect events act after the button tick
    if (evt_i.removal) begin
      step_d     = 2'd0;
      en_d       = 1'b0;
      level_d    = 1'b0;
      hold_d     = '0;
      counting_d = 1'b0;
    end else if (evt_i.plug_in && !en_q) begin
      en_d       = 1'b1;
      level_d    = 1'b0;
      hold_d     = '0;
      counting_d = 1'b0;
    end
  end

  assign armed_d_o = en_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= 1'b0;
      hold_q     <= '0;
      counting_q <= 1'b0;
      en_q       <= 1'b0;
      step_q     <= 2'd0;
    end else if (step_i) begin
      level_q    <= level_d;
      hold_q     <= hold_d;
      counting_q <= counting_d;
      en_q       <= en_d;
      step_q     <= step_d;
    end
  end

  // disarmed channel holds no debounce state
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_q |-> (!counting_q && !level_q && (hold_q == '0)))
    else $error("button state left over while disarmed");

endmodule

>>> design/jack_detect_button_debounce_top.sv
// Top level of the headset jack detect and button debounce block.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-------------------------------------
//  in      | in  | in_valid_i / in_stall_o   | detect_pin_i, button_pin_i
//  out     | out | out_valid_o / out_stall_i | jack_status_o, key_report_o,
//          |     |                           | button_armed_o
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request in, one result out. A request is held in an input register,
// then both channel updates run combinationally into the result register;
// a new request is taken every cycle unless in_stall_o is high.
// Reset puts the config registers at their defaults and all channel
// state to zero; the output holds no result.
// in_stall_o rises only while a request sits in the input register and the
// result register is full and stalled. Config writes are always taken.
module jack_detect_button_debounce_top
  import jdb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  detect_pin_i,
  input  logic                  button_pin_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  jack_status_o,
  output logic [1:0]            key_report_o,
  output logic                  button_armed_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgTickBits-1:0] cfg_data_i
);

  jdb_cfg_t cfg_q;

  logic     in_valid_q;
  logic     det_pin_q, btn_pin_q;
  logic     out_valid_q;
  logic     jack_q;
  key_e     key_q;
  logic     armed_q;

  logic     consume;
  logic     in_take;
  jdb_evt_t evt;
  key_e     key;
  logic     jack_d;
  logic     armed_d;

  // ---- config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_invert   <= 1'b1;
      cfg_q.button_invert   <= 1'b0;
      cfg_q.detect_debounce <= ticks_t'(20);
      cfg_q.button_debounce <= ticks_t'(2);
      cfg_q.long_press      <= ticks_t'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgDetectInvert:   cfg_q.detect_invert   <= cfg_data_i[0];
        CfgButtonInvert:   cfg_q.button_invert   <= cfg_data_i[0];
        CfgDetectDebounce: cfg_q.detect_debounce <= cfg_data_i;
        CfgButtonDebounce: cfg_q.button_debounce <= cfg_data_i;
        CfgLongPress:      cfg_q.long_press      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- handshake
  // the held request moves on when the result slot is free or draining
  assign consume    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !consume;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      det_pin_q <= detect_pin_i;
      btn_pin_q <= button_pin_i;
    end
  end

  // ---- channels
  jdb_detect u_detect (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (consume),
    .pin_i    (det_pin_q),
    .cfg_i    (cfg_q),
    .evt_o    (evt),
    .jack_d_o (jack_d)
  );

  jdb_button u_button (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (consume),
    .pin_i     (btn_pin_q),
    .cfg_i     (cfg_q),
    .evt_i     (evt),
    .key_o     (key),
    .armed_d_o (armed_d)
  );

  // ---- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      jack_q  <= jack_d;
      key_q   <= key;
      armed_q <= armed_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign jack_status_o  = jack_q;
  assign key_report_o   = key_q;
  assign button_armed_o = armed_q;

  // ---- checks
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_armed_jack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (button_armed_o == jack_status_o))
    else $error("button armed state disagrees with jack state");

  a_one_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (key_report_o != 2'd3))
    else $error("undefined key code reported");

endmodule
